// ===== sv/smx_pkg.sv =====
`timescale 1ns / 1ps

package smx_pkg;

    localparam int STACK_WORDS = 64;
    localparam int MEM_WORDS   = 16;
    localparam int WORD_W      = 32;
    localparam int SKIP_W      = 31;
    localparam int DEPTH_W     = 7;
    localparam int INDEX_W     = 4;
    localparam int SP_W        = $clog2(STACK_WORDS);
    localparam int CNT_W       = $clog2(STACK_WORDS + 1);
    localparam int MA_W        = $clog2(MEM_WORDS);

    // Both queue depths are powers of two so that the pointers wrap naturally.
    localparam int IQ_DEPTH    = 2;
    localparam int IQ_AW       = $clog2(IQ_DEPTH);
    localparam int RQ_DEPTH    = 4;
    localparam int RQ_AW       = $clog2(RQ_DEPTH);

    typedef enum logic [3:0] {
        OP_NOOP  = 4'd0,
        OP_ADD   = 4'd1,
        OP_NOR   = 4'd2,
        OP_IFZ   = 4'd3,
        OP_HALT  = 4'd4,
        OP_LOAD  = 4'd5,
        OP_STORE = 4'd6,
        OP_POP   = 4'd7,
        OP_PUSHI = 4'd8
    } opcode_t;

    typedef enum logic [2:0] {
        RS_DONE      = 3'd0,
        RS_SKIPPED   = 3'd1,
        RS_UNDERFLOW = 3'd2,
        RS_OVERFLOW  = 3'd3,
        RS_BAD_ADDR  = 3'd4,
        RS_IGNORED   = 3'd5
    } status_t;

    typedef struct packed {
        opcode_t             op;
        logic [WORD_W-1:0]   value;
        logic [SKIP_W-1:0]   skip;
    } dec_t;

    typedef struct packed {
        status_t             status;
        logic [WORD_W-1:0]   top;
        logic [DEPTH_W-1:0]  depth;
        logic                is_dump;
        logic [INDEX_W-1:0]  idx;
        logic [WORD_W-1:0]   value;
        logic                last;
    } res_t;

endpackage

// ===== sv/smx_front.sv =====
`timescale 1ns / 1ps

module smx_front
    import smx_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [3:0]          operation,
    input  logic [WORD_W-1:0]   parameter_req,
    output logic                deq_valid,
    output dec_t                deq_item,
    input  logic                deq_pop
);

    dec_t               q_reg [IQ_DEPTH];
    logic [IQ_AW-1:0]   wr_ptr_reg;
    logic [IQ_AW-1:0]   wr_ptr_next;
    logic [IQ_AW-1:0]   rd_ptr_reg;
    logic [IQ_AW-1:0]   rd_ptr_next;
    logic [IQ_AW:0]     cnt_reg;
    logic [IQ_AW:0]     cnt_next;
    dec_t               dec;
    logic               do_push;
    logic               do_pop;

    // Unknown operation codes behave as a no-operation.
    always_comb
    begin
        case (operation)
            OP_ADD, OP_NOR, OP_IFZ, OP_HALT, OP_LOAD, OP_STORE, OP_POP, OP_PUSHI:
                dec.op = opcode_t'(operation);
            default:
                dec.op = OP_NOOP;
        endcase
        dec.value = parameter_req;
        dec.skip  = parameter_req[WORD_W-1] ? '0 : parameter_req[SKIP_W-1:0];
    end

    assign full      = (cnt_reg == (IQ_AW+1)'(IQ_DEPTH));
    assign deq_valid = (cnt_reg != '0);
    assign deq_item  = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = deq_pop && deq_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ===== sv/smx_resq.sv =====
`timescale 1ns / 1ps

module smx_resq
    import smx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_push,
    input  res_t    res_item,
    output logic    res_full,
    output logic    empty,
    input  logic    pop,
    output res_t    head
);

    res_t               q_reg [RQ_DEPTH];
    logic [RQ_AW-1:0]   wr_ptr_reg;
    logic [RQ_AW-1:0]   rd_ptr_reg;
    logic [RQ_AW:0]     cnt_reg;
    logic [RQ_AW:0]     cnt_next;
    logic               do_push;
    logic               do_pop;

    assign res_full = (cnt_reg == (RQ_AW+1)'(RQ_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign head     = q_reg[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= res_item;
        end
    end

endmodule

// ===== sv/smx_back.sv =====
`timescale 1ns / 1ps

module smx_back
    import smx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  dec_t    in_item,
    output logic    in_pop,
    output logic    res_push,
    output res_t    res_item,
    input  logic    res_full
);

    typedef enum logic [3:0] {
        ST_EXEC = 4'b0001,
        ST_RD1  = 4'b0010,
        ST_RD2  = 4'b0100,
        ST_DUMP = 4'b1000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    opcode_t            op_reg;
    opcode_t            op_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [WORD_W-1:0]  tos_reg;
    logic [WORD_W-1:0]  tos_next;
    logic [SKIP_W-1:0]  skip_reg;
    logic [SKIP_W-1:0]  skip_next;
    logic               halted_reg;
    logic               halted_next;
    logic [MA_W-1:0]    dump_idx_reg;
    logic [MA_W-1:0]    dump_idx_next;
    logic [WORD_W-1:0]  dmem_reg [MEM_WORDS];
    logic [WORD_W-1:0]  stk_mem [STACK_WORDS];
    logic [WORD_W-1:0]  rdata_reg;

    logic               stk_we;
    logic [SP_W-1:0]    stk_waddr;
    logic [WORD_W-1:0]  stk_wdata;
    logic               stk_re;
    logic [SP_W-1:0]    stk_raddr;
    logic               dmem_we;
    logic [MA_W-1:0]    dmem_waddr;
    logic [WORD_W-1:0]  dmem_wdata;
    logic [MA_W-1:0]    dmem_raddr;
    logic [WORD_W-1:0]  dmem_rdata;
    logic               tos_bad;

    // The top of the stack lives in tos_reg; the memory holds the words below it.
    assign dmem_raddr = (state_reg == ST_DUMP) ? dump_idx_reg : tos_reg[MA_W-1:0];
    assign dmem_rdata = dmem_reg[dmem_raddr];
    assign tos_bad    = (tos_reg >= WORD_W'(MEM_WORDS));

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        count_next    = count_reg;
        tos_next      = tos_reg;
        skip_next     = skip_reg;
        halted_next   = halted_reg;
        dump_idx_next = dump_idx_reg;
        in_pop        = 1'b0;
        res_push      = 1'b0;
        stk_we        = 1'b0;
        stk_waddr     = SP_W'(count_reg - CNT_W'(1));
        stk_wdata     = tos_reg;
        stk_re        = 1'b0;
        stk_raddr     = SP_W'(count_reg - CNT_W'(2));
        dmem_we       = 1'b0;
        dmem_waddr    = tos_reg[MA_W-1:0];
        dmem_wdata    = rdata_reg;
        res_item      = '0;
        res_item.status = RS_DONE;
        res_item.last   = 1'b1;

        case (state_reg)
            ST_EXEC:
            begin
                if (in_valid && !res_full)
                begin
                    in_pop = 1'b1;
                    if (halted_reg)
                    begin
                        res_push        = 1'b1;
                        res_item.status = RS_IGNORED;
                    end
                    else if (skip_reg != '0)
                    begin
                        res_push        = 1'b1;
                        res_item.status = RS_SKIPPED;
                        skip_next       = skip_reg - 1'b1;
                    end
                    else
                    begin
                        case (in_item.op)
                            OP_ADD, OP_NOR, OP_STORE:
                            begin
                                if (count_reg < CNT_W'(2))
                                begin
                                    res_push        = 1'b1;
                                    res_item.status = RS_UNDERFLOW;
                                end
                                else if (in_item.op == OP_STORE && tos_bad)
                                begin
                                    res_push        = 1'b1;
                                    res_item.status = RS_BAD_ADDR;
                                end
                                else
                                begin
                                    stk_re     = 1'b1;
                                    op_next    = in_item.op;
                                    state_next = ST_RD1;
                                end
                            end
                            OP_IFZ, OP_POP:
                            begin
                                if (count_reg == '0)
                                begin
                                    res_push        = 1'b1;
                                    res_item.status = RS_UNDERFLOW;
                                end
                                else
                                begin
                                    if (in_item.op == OP_IFZ && tos_reg == '0)
                                    begin
                                        skip_next = in_item.skip;
                                    end
                                    stk_re     = 1'b1;
                                    op_next    = in_item.op;
                                    state_next = ST_RD1;
                                end
                            end
                            OP_LOAD:
                            begin
                                res_push = 1'b1;
                                if (count_reg == '0)
                                begin
                                    res_item.status = RS_UNDERFLOW;
                                end
                                else if (tos_bad)
                                begin
                                    res_item.status = RS_BAD_ADDR;
                                end
                                else
                                begin
                                    tos_next = dmem_rdata;
                                end
                            end
                            OP_PUSHI:
                            begin
                                res_push = 1'b1;
                                if (count_reg == CNT_W'(STACK_WORDS))
                                begin
                                    res_item.status = RS_OVERFLOW;
                                end
                                else
                                begin
                                    stk_we     = (count_reg != '0);
                                    tos_next   = in_item.value;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            OP_HALT:
                            begin
                                dump_idx_next = '0;
                                state_next    = ST_DUMP;
                            end
                            default:
                            begin
                                res_push = 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_RD1:
            begin
                case (op_reg)
                    OP_STORE:
                    begin
                        dmem_we    = 1'b1;
                        stk_re     = 1'b1;
                        stk_raddr  = SP_W'(count_reg - CNT_W'(3));
                        state_next = ST_RD2;
                    end
                    OP_ADD, OP_NOR:
                    begin
                        if (!res_full)
                        begin
                            res_push   = 1'b1;
                            tos_next   = (op_reg == OP_ADD) ? tos_reg + rdata_reg
                                                            : ~(tos_reg | rdata_reg);
                            count_next = count_reg - 1'b1;
                            state_next = ST_EXEC;
                        end
                    end
                    default:
                    begin
                        if (!res_full)
                        begin
                            res_push   = 1'b1;
                            tos_next   = rdata_reg;
                            count_next = count_reg - 1'b1;
                            state_next = ST_EXEC;
                        end
                    end
                endcase
            end
            ST_RD2:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    tos_next   = rdata_reg;
                    count_next = count_reg - CNT_W'(2);
                    state_next = ST_EXEC;
                end
            end
            ST_DUMP:
            begin
                if (!res_full)
                begin
                    res_push         = 1'b1;
                    res_item.is_dump = 1'b1;
                    res_item.idx     = INDEX_W'(dump_idx_reg);
                    res_item.value   = dmem_rdata;
                    res_item.last    = (dump_idx_reg == MA_W'(MEM_WORDS - 1));
                    if (res_item.last)
                    begin
                        halted_next = 1'b1;
                        state_next  = ST_EXEC;
                    end
                    else
                    begin
                        dump_idx_next = dump_idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_EXEC;
            end
        endcase

        res_item.depth = DEPTH_W'(count_next);
        res_item.top   = (count_next == '0) ? '0 : tos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_EXEC;
            op_reg       <= OP_NOOP;
            count_reg    <= '0;
            skip_reg     <= '0;
            halted_reg   <= 1'b0;
            dump_idx_reg <= '0;
            for (int i = 0; i < MEM_WORDS; i++)
            begin
                dmem_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            count_reg    <= count_next;
            skip_reg     <= skip_next;
            halted_reg   <= halted_next;
            dump_idx_reg <= dump_idx_next;
            if (dmem_we)
            begin
                dmem_reg[dmem_waddr] <= dmem_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            rdata_reg <= stk_mem[stk_raddr];
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_WORDS))
        else $error("stack count beyond capacity");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halted flag cleared");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_pop_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_pop |-> (state_reg == ST_EXEC && in_valid))
        else $error("request taken outside the execute state");

    a_dump_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP && res_push && !res_item.last)
            |=> (state_reg == ST_DUMP && dump_idx_reg == $past(dump_idx_reg) + 1'b1))
        else $error("dump index did not advance");

endmodule

// ===== sv/stack_machine_executor.sv =====
`timescale 1ns / 1ps
// NOOP, PUSHI, LOAD and faults finish in ST_EXEC; ADD, NOR, IFZ and POP go through ST_RD1,
// STORE through ST_RD1 and ST_RD2, and a halt dumps the data memory word by word in ST_DUMP.
// Requests are taken one a cycle for NOOP, PUSHI, LOAD and faults while the result queue has
// room; no new request leaves the request queue until ST_RD1, ST_RD2 or ST_DUMP is left.
// Reset clears the stack count, skip counter, halted flag, data memory and both queues.

module stack_machine_executor
    import smx_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [3:0]          operation,
    input  logic signed [31:0]  parameter_req,
    output logic                empty,
    input  logic                pop,
    output logic [2:0]          status,
    output logic signed [31:0]  top_value,
    output logic [6:0]          stack_depth,
    output logic                is_dump,
    output logic [3:0]          dump_index,
    output logic signed [31:0]  dump_value,
    output logic                last
);

    logic   deq_valid;
    dec_t   deq_item;
    logic   deq_pop;
    logic   res_push;
    res_t   res_item;
    logic   res_full;
    res_t   head;

    smx_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .parameter_req (parameter_req),
        .deq_valid     (deq_valid),
        .deq_item      (deq_item),
        .deq_pop       (deq_pop)
    );

    smx_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (deq_valid),
        .in_item  (deq_item),
        .in_pop   (deq_pop),
        .res_push (res_push),
        .res_item (res_item),
        .res_full (res_full)
    );

    smx_resq u_resq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_item (res_item),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign status      = head.status;
    assign top_value   = head.top;
    assign stack_depth = head.depth;
    assign is_dump     = head.is_dump;
    assign dump_index  = head.idx;
    assign dump_value  = head.value;
    assign last        = head.last;

endmodule
